FILE: rtl/core/ladsr_pkg.sv
// Shared types and constants for the linear ADSR envelope with voice steal.
// No dependencies; every other file of the block imports this package.
package ladsr_pkg;

	// Levels are Q1.22 fractions held in 23 unsigned bits (1.0 is the top value).
	localparam logic [22:0] LVL_ONE    = 23'd4194304;
	localparam logic [22:0] LVL_TENTH  = 23'd419430;
	localparam logic [22:0] LVL_EPS    = 23'd41;
	localparam logic [23:0] UNIT_ROUND = 24'd32767;
	localparam logic [4:0]  DIV_BITS   = 5'd23;

	localparam logic [1:0] CMD_TICK     = 2'd0;
	localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
	localparam logic [1:0] CMD_NOTE_OFF = 2'd2;

	localparam logic [2:0] REG_ATTACK  = 3'd0;
	localparam logic [2:0] REG_DECAY   = 3'd1;
	localparam logic [2:0] REG_RELEASE = 3'd2;
	localparam logic [2:0] REG_STEAL   = 3'd3;
	localparam logic [2:0] REG_SUSTAIN = 3'd4;
	localparam logic [2:0] REG_IGNORE  = 3'd5;
	localparam logic [2:0] REG_CLICK   = 3'd6;

	localparam logic [2:0] STG_IDLE    = 3'd0;
	localparam logic [2:0] STG_ATTACK  = 3'd1;
	localparam logic [2:0] STG_DECAY   = 3'd2;
	localparam logic [2:0] STG_SUSTAIN = 3'd3;
	localparam logic [2:0] STG_RELEASE = 3'd4;

	typedef struct packed {
		logic [1:0] cmd;
		logic [6:0] note_id;
		logic       sample_present;
	} req_t;

	typedef struct packed {
		logic [15:0] env_level;
		logic [2:0]  stage;
		logic        gate_on;
		logic [6:0]  playing_note;
		logic        steal_pending;
	} rsp_t;

	typedef struct packed {
		logic [19:0] attack_unit;
		logic [19:0] decay_unit;
		logic [19:0] release_unit;
		logic [19:0] steal_unit;
		logic [7:0]  sustain;
		logic        ignore_rel;
		logic [15:0] click_fade;
	} cfg_t;

	typedef struct packed {
		logic       wr;
		logic [2:0] idx;
		logic       chg;
	} cfg_ev_t;

	typedef enum logic [2:0] {
		DP_NOP    = 3'd0,
		DP_JUMP   = 3'd1,
		DP_RAMP   = 3'd2,
		DP_STEP   = 3'd3,
		DP_FINISH = 3'd4,
		DP_SUS    = 3'd5,
		DP_CLEAR  = 3'd6,
		DP_ENVQ   = 3'd7
	} dp_op_t;

	typedef enum logic [1:0] {
		TGT_ZERO = 2'd0,
		TGT_ONE  = 2'd1,
		TGT_SUS  = 2'd2
	} tgt_t;

	typedef struct packed {
		dp_op_t      op;
		tgt_t        tgt;
		logic [19:0] unit;
	} dp_cmd_t;

	typedef struct packed {
		logic jump;
		logic steps_zero;
		logic busy;
		logic gt_tenth;
	} dp_sts_t;

	typedef struct packed {
		logic       idle;
		logic       out_load;
		logic [2:0] stage;
		logic       held;
		logic [6:0] note;
		logic       pending;
	} ctrl_sts_t;

endpackage

FILE: rtl/core/ladsr_dp.sv
// Envelope datapath: level, ramp increment, step count, output level and the
// serial divider that forms the increment. Depends on ladsr_pkg.
module ladsr_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  ladsr_pkg::dp_cmd_t cmd,
	input  logic [7:0]        sus,
	output ladsr_pkg::dp_sts_t sts,
	output logic [22:0]       env_q
);
	import ladsr_pkg::*;

	logic [22:0]        level_q, target_q, envq_q, mag_q, quo_q, tgt_val, mag_w;
	logic signed [23:0] step_q;
	logic [27:0]        steps_q, rem_q, prod;
	logic [19:0]        unit_q;
	logic               neg_q, busy_q, mul_q;
	logic [4:0]         cnt_q;
	logic [24:0]        diff, negd, lvl_sum;
	logic [23:0]        units_sum;
	logic [7:0]         units;
	logic [28:0]        trial;
	logic [23:0]        quo_ext;

	always_comb begin
		case (cmd.tgt)
			TGT_ONE: tgt_val = LVL_ONE;
			TGT_SUS: tgt_val = {sus, 15'd0};
			default: tgt_val = '0;
		endcase
	end

	assign diff      = {2'b00, tgt_val} - {2'b00, level_q};
	assign negd      = -diff;
	assign mag_w     = diff[24] ? negd[22:0] : diff[22:0];
	assign units_sum = {1'b0, mag_q} + UNIT_ROUND;
	assign units     = units_sum[22:15];
	assign prod      = {8'd0, unit_q} * {20'd0, units};
	assign trial     = {rem_q, quo_q[22]} - {1'b0, steps_q};
	assign lvl_sum   = {2'b00, level_q} + {step_q[23], step_q};
	assign quo_ext   = {1'b0, quo_q};

	assign sts.jump       = (mag_w <= LVL_EPS) || (cmd.unit == 20'd0);
	assign sts.steps_zero = (steps_q == 28'd0);
	assign sts.busy       = busy_q;
	assign sts.gt_tenth   = (level_q > LVL_TENTH);
	assign env_q          = envq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			target_q <= '0;
			envq_q   <= '0;
			step_q   <= '0;
			steps_q  <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			mag_q    <= '0;
			neg_q    <= 1'b0;
			unit_q   <= '0;
			busy_q   <= 1'b0;
			mul_q    <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (busy_q) begin
				if (mul_q) begin
					steps_q <= prod;
					rem_q   <= '0;
					quo_q   <= mag_q;
					cnt_q   <= DIV_BITS;
					mul_q   <= 1'b0;
				end else if (cnt_q != 5'd0) begin
					if (!trial[28]) begin
						rem_q <= trial[27:0];
						quo_q <= {quo_q[21:0], 1'b1};
					end else begin
						rem_q <= {rem_q[26:0], quo_q[22]};
						quo_q <= {quo_q[21:0], 1'b0};
					end
					cnt_q <= cnt_q - 5'd1;
				end else begin
					step_q <= neg_q ? -$signed(quo_ext) : $signed(quo_ext);
					busy_q <= 1'b0;
				end
			end
			case (cmd.op)
				DP_JUMP: begin
					level_q  <= tgt_val;
					target_q <= tgt_val;
					steps_q  <= '0;
					step_q   <= '0;
				end
				DP_RAMP: begin
					target_q <= tgt_val;
					mag_q    <= mag_w;
					neg_q    <= diff[24];
					unit_q   <= cmd.unit;
					busy_q   <= 1'b1;
					mul_q    <= 1'b1;
				end
				DP_STEP: begin
					level_q <= lvl_sum[22:0];
					steps_q <= steps_q - 28'd1;
				end
				DP_FINISH: begin
					level_q <= target_q;
					steps_q <= '0;
				end
				DP_SUS: begin
					level_q <= {sus, 15'd0};
					envq_q  <= {sus, 15'd0};
					steps_q <= '0;
					step_q  <= '0;
				end
				DP_CLEAR: begin
					level_q  <= '0;
					target_q <= '0;
					envq_q   <= '0;
					steps_q  <= '0;
					step_q   <= '0;
				end
				DP_ENVQ: begin
					envq_q <= level_q;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/ladsr_ctrl.sv
// Envelope controller: stage sequencing, note and steal bookkeeping, click
// fade counter and the commands that drive ladsr_dp. Depends on ladsr_pkg.
module ladsr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_acc,
	input  ladsr_pkg::req_t      req,
	input  ladsr_pkg::cfg_ev_t   cfg_ev,
	input  ladsr_pkg::cfg_t      cfg,
	input  logic                out_free,
	input  ladsr_pkg::dp_sts_t   dp_sts,
	output ladsr_pkg::dp_cmd_t   dp_cmd,
	output ladsr_pkg::ctrl_sts_t sts
);
	import ladsr_pkg::*;

	typedef enum logic [6:0] {
		S_WAIT  = 7'b0000001,
		S_CMD   = 7'b0000010,
		S_TCHK  = 7'b0000100,
		S_ENTER = 7'b0001000,
		S_RAMP  = 7'b0010000,
		S_DIVW  = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t      state_q, state_d;
	logic        out_q, out_d;
	logic [2:0]  stage_q, stage_d;
	logic        held_q, held_d, pend_q, pend_d, ppres_q, ppres_d, sv_q, sv_d;
	logic [6:0]  pnote_q, pnote_d, note_q, note_d;
	logic        fade_act_q, fade_act_d, steal_q, steal_d;
	logic        tick_fin_q, tick_fin_d, cfg_op_q, cfg_op_d;
	logic [15:0] fade_left_q, fade_left_d;
	req_t        item_q, item_d;
	logic        adv, do_start, from_pend, st_pres, out_load;
	logic [6:0]  st_note;
	logic        ramp_stage;

	function automatic logic [2:0] next_stg(input logic [2:0] s, input logic [7:0] sus,
			input logic [19:0] du);
		logic [2:0] r;
		r = s;
		case (s)
			STG_ATTACK:  r = (sus < 8'd128 || du != 20'd0) ? STG_DECAY : STG_SUSTAIN;
			STG_DECAY:   r = STG_SUSTAIN;
			STG_RELEASE: r = STG_IDLE;
			default:     r = s;
		endcase
		return r;
	endfunction

	assign ramp_stage = (stage_q == STG_ATTACK) || (stage_q == STG_DECAY) ||
		(stage_q == STG_RELEASE);

	// Ramp target and unit follow the stage; the steal ramp uses its own unit.
	always_comb begin
		dp_cmd.op   = DP_NOP;
		dp_cmd.tgt  = TGT_ZERO;
		dp_cmd.unit = '0;
		case (stage_q)
			STG_ATTACK: begin
				dp_cmd.tgt  = TGT_ONE;
				dp_cmd.unit = cfg.attack_unit;
			end
			STG_DECAY: begin
				dp_cmd.tgt  = TGT_SUS;
				dp_cmd.unit = cfg.decay_unit;
			end
			STG_RELEASE: begin
				dp_cmd.unit = steal_q ? cfg.steal_unit : cfg.release_unit;
			end
			default: begin
			end
		endcase

		state_d     = state_q;
		out_d       = out_q;
		stage_d     = stage_q;
		held_d      = held_q;
		pend_d      = pend_q;
		ppres_d     = ppres_q;
		pnote_d     = pnote_q;
		sv_d        = sv_q;
		note_d      = note_q;
		fade_act_d  = fade_act_q;
		fade_left_d = fade_left_q;
		steal_d     = steal_q;
		tick_fin_d  = tick_fin_q;
		cfg_op_d    = cfg_op_q;
		item_d      = item_q;
		adv         = 1'b0;
		do_start    = 1'b0;
		from_pend   = 1'b0;
		out_load    = 1'b0;

		case (state_q)
			S_WAIT: begin
				if (out_q && out_free) begin
					out_load = 1'b1;
					out_d    = 1'b0;
				end else if (cfg_ev.wr) begin
					cfg_op_d   = 1'b1;
					tick_fin_d = 1'b0;
					steal_d    = 1'b0;
					if (cfg_ev.chg) begin
						case (cfg_ev.idx)
							REG_ATTACK:  if (stage_q == STG_ATTACK) state_d = S_RAMP;
							REG_DECAY:   if (stage_q == STG_DECAY) state_d = S_RAMP;
							REG_RELEASE: if (stage_q == STG_RELEASE) state_d = S_RAMP;
							REG_SUSTAIN: begin
								if (stage_q == STG_DECAY) state_d = S_RAMP;
								else if (stage_q == STG_SUSTAIN) state_d = S_ENTER;
							end
							default: begin
							end
						endcase
					end
				end else if (req_acc) begin
					item_d     = req;
					cfg_op_d   = 1'b0;
					tick_fin_d = 1'b0;
					steal_d    = 1'b0;
					state_d    = S_CMD;
				end
			end
			S_CMD: begin
				case (item_q.cmd)
					CMD_TICK: begin
						tick_fin_d = 1'b1;
						if (ramp_stage) begin
							if (dp_sts.steps_zero) begin
								dp_cmd.op = DP_FINISH;
								adv       = 1'b1;
							end else begin
								dp_cmd.op = DP_STEP;
								state_d   = S_TCHK;
							end
						end else if (stage_q == STG_SUSTAIN) begin
							dp_cmd.op = DP_SUS;
							state_d   = S_FIN;
						end else if (pend_q) begin
							do_start  = 1'b1;
							from_pend = 1'b1;
						end else begin
							dp_cmd.op = DP_CLEAR;
							state_d   = S_FIN;
						end
					end
					CMD_NOTE_ON: begin
						if (stage_q != STG_IDLE && dp_sts.gt_tenth && sv_q) begin
							pend_d  = 1'b1;
							pnote_d = item_q.note_id;
							ppres_d = item_q.sample_present;
							if (stage_q != STG_RELEASE && cfg.release_unit == 20'd0) begin
								stage_d     = STG_IDLE;
								fade_act_d  = 1'b1;
								fade_left_d = cfg.click_fade;
								dp_cmd.op   = DP_CLEAR;
								state_d     = S_FIN;
							end else begin
								stage_d = STG_RELEASE;
								steal_d = 1'b1;
								state_d = S_RAMP;
							end
						end else begin
							do_start = 1'b1;
						end
					end
					CMD_NOTE_OFF: begin
						state_d = S_FIN;
						if (sv_q && !cfg.ignore_rel) begin
							held_d = 1'b0;
							if (stage_q != STG_IDLE && stage_q != STG_RELEASE) begin
								stage_d = STG_RELEASE;
								state_d = S_ENTER;
							end
						end
					end
					default: state_d = S_FIN;
				endcase
			end
			S_TCHK: begin
				if (pend_q && stage_q == STG_RELEASE && !dp_sts.gt_tenth) begin
					do_start  = 1'b1;
					from_pend = 1'b1;
				end else if (dp_sts.steps_zero) begin
					dp_cmd.op = DP_FINISH;
					adv       = 1'b1;
				end else begin
					state_d = S_FIN;
				end
			end
			S_ENTER: begin
				if (ramp_stage) begin
					state_d = S_RAMP;
				end else if (stage_q == STG_SUSTAIN) begin
					dp_cmd.op = DP_SUS;
					state_d   = S_FIN;
				end else begin
					dp_cmd.op = DP_CLEAR;
					state_d   = S_FIN;
				end
			end
			S_RAMP: begin
				steal_d = 1'b0;
				if (dp_sts.jump) begin
					dp_cmd.op = DP_JUMP;
					adv       = 1'b1;
				end else begin
					dp_cmd.op = DP_RAMP;
					state_d   = S_DIVW;
				end
			end
			S_DIVW: begin
				if (!dp_sts.busy) state_d = S_FIN;
			end
			S_FIN: begin
				if (tick_fin_q) begin
					dp_cmd.op = DP_ENVQ;
					if (fade_act_q) begin
						if (fade_left_q != 16'd0) fade_left_d = fade_left_q - 16'd1;
						else fade_act_d = 1'b0;
					end
				end
				if (!cfg_op_q) out_d = 1'b1;
				state_d = S_WAIT;
			end
			default: state_d = S_WAIT;
		endcase

		if (adv) begin
			stage_d = next_stg(stage_q, cfg.sustain, cfg.decay_unit);
			if (stage_q == STG_RELEASE) begin
				fade_act_d  = 1'b1;
				fade_left_d = cfg.click_fade;
			end
			state_d = S_ENTER;
		end

		st_note = from_pend ? pnote_q : item_q.note_id;
		st_pres = from_pend ? ppres_q : item_q.sample_present;
		if (do_start) begin
			dp_cmd.op   = DP_CLEAR;
			fade_act_d  = 1'b0;
			fade_left_d = '0;
			tick_fin_d  = 1'b0;
			if (from_pend) pend_d = 1'b0;
			sv_d    = st_pres;
			note_d  = st_note;
			held_d  = st_pres;
			stage_d = st_pres ? STG_ATTACK : STG_IDLE;
			state_d = st_pres ? S_ENTER : S_FIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_WAIT;
			out_q       <= 1'b0;
			stage_q     <= STG_IDLE;
			held_q      <= 1'b0;
			pend_q      <= 1'b0;
			ppres_q     <= 1'b0;
			pnote_q     <= '0;
			sv_q        <= 1'b0;
			note_q      <= '0;
			fade_act_q  <= 1'b0;
			fade_left_q <= '0;
			steal_q     <= 1'b0;
			tick_fin_q  <= 1'b0;
			cfg_op_q    <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_q       <= out_d;
			stage_q     <= stage_d;
			held_q      <= held_d;
			pend_q      <= pend_d;
			ppres_q     <= ppres_d;
			pnote_q     <= pnote_d;
			sv_q        <= sv_d;
			note_q      <= note_d;
			fade_act_q  <= fade_act_d;
			fade_left_q <= fade_left_d;
			steal_q     <= steal_d;
			tick_fin_q  <= tick_fin_d;
			cfg_op_q    <= cfg_op_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
	end

	assign sts.idle     = (state_q == S_WAIT) && !out_q;
	assign sts.out_load = out_load;
	assign sts.stage    = stage_q;
	assign sts.held     = held_q;
	assign sts.note     = note_q;
	assign sts.pending  = pend_q;

	// The click fade only ever runs after a release has ended in idle or a steal has cleared the voice.
	a_fade_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fade_act_q |-> stage_q == STG_IDLE)
		else $error("click fade active outside idle");

	a_div_stage: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIVW |-> (stage_q == STG_ATTACK || stage_q == STG_DECAY ||
			stage_q == STG_RELEASE))
		else $error("ramp division outside a ramp stage");

	a_ramp_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RAMP |=> (state_q == S_ENTER || state_q == S_DIVW))
		else $error("ramp setup went to an unexpected state");

endmodule

FILE: rtl/core/linear_adsr_envelope_with_steal_unit.sv
// Top level of the linear ADSR envelope with voice steal: configuration
// registers, result register and the controller/datapath pair.
// Depends on ladsr_pkg, ladsr_ctrl and ladsr_dp.
//
// Each item is one command for a single voice: a sample tick, a note on or a
// note off, and each item produces exactly one result that shows the envelope
// after the command. A ramp moves the Q1.22 level by a fixed increment per
// tick; the increment is the ramp distance divided by the step count, formed
// by a bit-serial divider that yields one quotient bit per cycle. A plain
// tick, note off or sustain update needs no division; a command or tick that
// starts a new ramp adds the step-count multiply and the division, and a tick
// that starts a waiting note whose attack jumps straight into a decay ramp is
// the longest case. The block takes one item at a time; the next item is
// accepted once the controller is back in its wait state with its result
// handed on and no configuration write offered, even while the previous
// result still sits in the result register. Configuration writes are taken
// only while no item is being worked on; a write to a rate or sustain
// register whose stage is running retargets that ramp from the current level
// (a sustain write in the sustain stage sets the level), which keeps the
// configuration port busy until the controller waits again. A note on that
// arrives while the voice is audible above one tenth of full scale starts a
// fast release at the steal rate (or clears the voice if the release rate is
// zero outside a release), and the held note starts once the level falls to
// one tenth or below. The click fade after a release or such a clear counts
// down while the voice is idle.
module linear_adsr_envelope_with_steal_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ladsr_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ladsr_pkg::rsp_t   rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [19:0]       cfg_data
);
	import ladsr_pkg::*;

	cfg_t      cfg_q;
	cfg_ev_t   cfg_ev;
	dp_cmd_t   dp_cmd;
	dp_sts_t   dp_sts;
	ctrl_sts_t c_sts;
	rsp_t      rsp_q;
	logic      rsp_valid_q;
	logic [22:0] env_q;
	logic [7:0]  sus_sat;
	logic        req_acc, out_free;

	// The controller takes configuration ahead of a command in the same cycle.
	assign cfg_ready = c_sts.idle;
	assign req_stall = !c_sts.idle || cfg_valid;
	assign req_acc   = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Sustain above full scale saturates to full scale.
	assign sus_sat = (cfg_data[7:0] > 8'd128) ? 8'd128 : cfg_data[7:0];

	always_comb begin
		cfg_ev.wr  = cfg_valid && cfg_ready;
		cfg_ev.idx = cfg_index;
		case (cfg_index)
			REG_ATTACK:  cfg_ev.chg = (cfg_data != cfg_q.attack_unit);
			REG_DECAY:   cfg_ev.chg = (cfg_data != cfg_q.decay_unit);
			REG_RELEASE: cfg_ev.chg = (cfg_data != cfg_q.release_unit);
			REG_SUSTAIN: cfg_ev.chg = (sus_sat != cfg_q.sustain);
			default:     cfg_ev.chg = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_unit  <= 20'd256;
			cfg_q.decay_unit   <= 20'd256;
			cfg_q.release_unit <= 20'd256;
			cfg_q.steal_unit   <= 20'd1;
			cfg_q.sustain      <= 8'd128;
			cfg_q.ignore_rel   <= 1'b0;
			cfg_q.click_fade   <= 16'd64;
		end else if (cfg_ev.wr) begin
			case (cfg_index)
				REG_ATTACK:  cfg_q.attack_unit  <= cfg_data;
				REG_DECAY:   cfg_q.decay_unit   <= cfg_data;
				REG_RELEASE: cfg_q.release_unit <= cfg_data;
				REG_STEAL:   cfg_q.steal_unit   <= cfg_data;
				REG_SUSTAIN: cfg_q.sustain      <= sus_sat;
				REG_IGNORE:  cfg_q.ignore_rel   <= cfg_data[0];
				REG_CLICK:   cfg_q.click_fade   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	ladsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_acc  (req_acc),
		.req      (req),
		.cfg_ev   (cfg_ev),
		.cfg      (cfg_q),
		.out_free (out_free),
		.dp_sts   (dp_sts),
		.dp_cmd   (dp_cmd),
		.sts      (c_sts)
	);

	ladsr_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dp_cmd),
		.sus    (cfg_q.sustain),
		.sts    (dp_sts),
		.env_q  (env_q)
	);

	// Result register: loaded when the controller finishes an item and the
	// previous result has been taken or is being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (c_sts.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (c_sts.out_load) begin
			rsp_q.env_level     <= env_q[22:7];
			rsp_q.stage         <= c_sts.stage;
			rsp_q.gate_on       <= c_sts.held;
			rsp_q.playing_note  <= c_sts.note;
			rsp_q.steal_pending <= c_sts.pending;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
